FILE: rtl/core/lga_pkg.sv
package lga_pkg;

	localparam int MAX_FEATURES = 16;
	// Count width holds the feature count register, an input index and MAX_FEATURES itself.
	localparam int CNT_W = ($clog2(MAX_FEATURES + 1) > 5) ? $clog2(MAX_FEATURES + 1) : 5;

	localparam logic [2:0] MODE_LOAD   = 3'd0;
	localparam logic [2:0] MODE_SAMPLE = 3'd1;
	localparam logic [2:0] MODE_LABEL  = 3'd2;
	localparam logic [2:0] MODE_READ   = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	localparam logic REG_FEATURE_COUNT = 1'b0;
	localparam logic REG_FRAC_SHIFT    = 1'b1;

	localparam logic [4:0] FEATURE_COUNT_RST = 5'd16;
	localparam logic [4:0] FRAC_SHIFT_RST    = 5'd8;

	typedef struct packed {
		logic [2:0]         mode;
		logic [3:0]         feature_index;
		logic signed [15:0] weight_value;
		logic signed [7:0]  sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] gradient_value;
		logic [3:0]         gradient_index;
	} out_item_t;

	typedef struct packed {
		logic               load_we;
		logic               sample_we;
		logic               clear;
		logic [CNT_W-1:0]   index;
		logic signed [15:0] weight;
		logic signed [7:0]  sample;
		logic [CNT_W-1:0]   count;
		logic [4:0]         shift;
	} cell_cmd_t;

	typedef struct packed {
		logic               busy;
		logic signed [15:0] weight;
		logic signed [31:0] grad;
	} cell_stat_t;

endpackage

FILE: rtl/core/lga_in_if.sv
interface lga_in_if;
	logic               valid;
	logic               ready;
	lga_pkg::in_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/lga_out_if.sv
interface lga_out_if;
	logic               valid;
	logic               ready;
	lga_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/lga_cell.sv
module lga_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lga_pkg::cell_cmd_t          cmd,
	input  logic [lga_pkg::CNT_W-1:0]   cell_id,
	input  logic                        tok_in,
	input  logic signed [31:0]          err_in,
	output logic                        tok_out,
	output logic signed [31:0]          err_out,
	output lga_pkg::cell_stat_t         stat
);

	logic signed [15:0] weight_q;
	logic signed [7:0]  sample_q;
	logic signed [31:0] grad_q;
	logic               tok_q;
	logic signed [31:0] err_q;
	logic               upd_s1;
	logic signed [31:0] prod_s1;
	logic signed [39:0] prod_full;
	logic               hit;
	logic               active;

	assign hit       = (cmd.index == cell_id);
	assign active    = (cell_id < cmd.count);
	assign prod_full = sample_q * err_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			upd_s1 <= 1'b0;
			grad_q <= '0;
		end else begin
			tok_q  <= tok_in;
			upd_s1 <= tok_in && active;
			if (cmd.clear) begin
				grad_q <= '0;
			end else if (upd_s1) begin
				grad_q <= grad_q - (prod_s1 >>> cmd.shift);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we && hit) begin
			weight_q <= cmd.weight;
		end
		if (cmd.sample_we && hit) begin
			sample_q <= cmd.sample;
		end
		if (tok_in) begin
			err_q   <= err_in;
			prod_s1 <= prod_full[31:0];
		end
	end

	assign tok_out     = tok_q;
	assign err_out     = err_q;
	assign stat.busy   = tok_q || upd_s1;
	assign stat.weight = weight_q;
	assign stat.grad   = grad_q;

endmodule

FILE: rtl/core/linreg_gradient_accumulator_core.sv
// Load, sample, clear and read items are taken one per cycle while no update is
// in flight and the output register is free or drained; a read result is offered
// in the output register in the cycle after its transfer. A label item starts an
// error token down the row of feature cells, one cell per cycle; input stays
// stalled until the token and the updates it starts have cleared the whole row.
// Reset clears gradients, the dot product and control state and loads the default
// feature count and fractional shift; weights and buffered samples stay unknown.
module linreg_gradient_accumulator_core (
	input  logic          clk,
	input  logic          arst_n,
	lga_in_if.sink        sample_in,
	lga_out_if.source     grad_out,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int NCELL = lga_pkg::MAX_FEATURES;
	localparam int CW    = lga_pkg::CNT_W;

	logic [4:0]          feature_count_q;
	logic [4:0]          frac_shift_q;
	logic signed [31:0]  dot_q;
	logic                head_tok_q;
	logic signed [31:0]  head_err_q;
	logic                out_valid_q;
	lga_pkg::out_item_t  out_data_q;

	lga_pkg::cell_cmd_t  cmd;
	lga_pkg::cell_stat_t stat [NCELL];
	logic                tok_w [NCELL+1];
	logic signed [31:0]  err_w [NCELL+1];
	logic [NCELL-1:0]    tok_vec;

	logic                acc;
	logic                cfg_we;
	logic                chain_busy;
	logic [CW-1:0]       active_n;
	logic [CW-1:0]       idx_ext;
	logic                idx_in_row;
	logic signed [15:0]  sel_weight;
	logic signed [31:0]  sel_grad;
	logic signed [23:0]  sw_prod;
	logic signed [31:0]  label_ext;
	logic signed [31:0]  err_next;

	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == lga_pkg::REG_FRAC_SHIFT) ? {27'd0, frac_shift_q}
		: {27'd0, feature_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_count_q <= lga_pkg::FEATURE_COUNT_RST;
			frac_shift_q    <= lga_pkg::FRAC_SHIFT_RST;
		end else if (cfg_we) begin
			if (paddr[2] == lga_pkg::REG_FEATURE_COUNT) begin
				feature_count_q <= pwdata[4:0];
			end else begin
				frac_shift_q <= pwdata[4:0];
			end
		end
	end

	assign active_n = (CW'(feature_count_q) > CW'(NCELL)) ? CW'(NCELL) : CW'(feature_count_q);
	assign idx_ext    = CW'(sample_in.data.feature_index);
	assign idx_in_row = idx_ext < active_n;

	always_comb begin
		chain_busy = head_tok_q;
		for (int i = 0; i < NCELL; i++) begin
			chain_busy = chain_busy || stat[i].busy;
		end
	end

	assign sample_in.ready = !chain_busy && (!out_valid_q || grad_out.ready);
	assign acc = sample_in.valid && sample_in.ready;

	// Weight and gradient of the addressed cell; an index past the last cell reads zero.
	always_comb begin
		sel_weight = '0;
		sel_grad   = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (CW'(i) == idx_ext) begin
				sel_weight = stat[i].weight;
				sel_grad   = stat[i].grad;
			end
		end
	end

	assign sw_prod   = sample_in.data.sample_value * sel_weight;
	assign label_ext = {{24{sample_in.data.sample_value[7]}}, sample_in.data.sample_value};
	assign err_next  = (label_ext <<< frac_shift_q) - dot_q;

	always_comb begin
		cmd.load_we   = acc && (sample_in.data.mode == lga_pkg::MODE_LOAD);
		cmd.sample_we = acc && (sample_in.data.mode == lga_pkg::MODE_SAMPLE) && idx_in_row;
		cmd.clear     = acc && (sample_in.data.mode == lga_pkg::MODE_CLEAR);
		cmd.index     = idx_ext;
		cmd.weight    = sample_in.data.weight_value;
		cmd.sample    = sample_in.data.sample_value;
		cmd.count     = active_n;
		cmd.shift     = frac_shift_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			head_tok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_tok_q <= 1'b0;
			if (grad_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (acc) begin
				case (sample_in.data.mode)
					lga_pkg::MODE_SAMPLE: begin
						if (idx_in_row) begin
							dot_q <= dot_q + {{8{sw_prod[23]}}, sw_prod};
						end
					end
					lga_pkg::MODE_LABEL: begin
						dot_q      <= '0;
						head_tok_q <= 1'b1;
					end
					lga_pkg::MODE_READ: begin
						out_valid_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (sample_in.data.mode == lga_pkg::MODE_LABEL)) begin
			head_err_q <= err_next;
		end
		if (acc && (sample_in.data.mode == lga_pkg::MODE_READ)) begin
			out_data_q.gradient_value <= sel_grad;
			out_data_q.gradient_index <= sample_in.data.feature_index;
		end
	end

	assign grad_out.valid = out_valid_q;
	assign grad_out.data  = out_data_q;

	assign tok_w[0] = head_tok_q;
	assign err_w[0] = head_err_q;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		lga_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.cell_id (CW'(g)),
			.tok_in  (tok_w[g]),
			.err_in  (err_w[g]),
			.tok_out (tok_w[g+1]),
			.err_out (err_w[g+1]),
			.stat    (stat[g])
		);
		assign tok_vec[g] = tok_w[g+1];
	end

	// The error token passes along the row alone.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vec, head_tok_q}))
		else $error("more than one error token in the cell row");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		chain_busy |-> !sample_in.ready)
		else $error("input taken while gradient update in flight");

	a_label_clears_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && sample_in.data.mode == lga_pkg::MODE_LABEL) |=> (dot_q == '0) && head_tok_q)
		else $error("label did not clear the dot product or start the token");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && sample_in.data.mode == lga_pkg::MODE_READ) |=> out_valid_q)
		else $error("gradient read produced no result");

	a_no_result_otherwise: assert property (@(posedge clk) disable iff (!arst_n)
		(!acc || sample_in.data.mode != lga_pkg::MODE_READ) && grad_out.ready |=> !out_valid_q)
		else $error("result appeared without a gradient read");

endmodule
